// ===== src/atb_pkg.sv =====
`timescale 1ns / 1ps
package atb_pkg;

   // accumulator width for mantissa and divisor (24..64)
   localparam int ACC_BITS = 48;

   // string queue between parser and arithmetic back end
   localparam int QUEUE_DEPTH = 2;

   // unit codes
   localparam logic [1:0] UNIT_DEG  = 2'd0;
   localparam logic [1:0] UNIT_GON  = 2'd1;
   localparam logic [1:0] UNIT_RAD  = 2'd2;
   localparam logic [1:0] UNIT_RSVD = 2'd3;

   // 2^63 / units-per-rotation, rounded; 32 fraction bits
   localparam logic [63:0] SCALE_DEG = 64'd25620477880152155;
   localparam logic [63:0] SCALE_GON = 64'd23058430092136940;
   localparam logic [63:0] SCALE_RAD = 64'd1467945251641000613;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic signed [31:0] bin_angle;
      logic               overflow;
      logic [1:0]         unit_used;
   } rsp_type;

   // one parsed string handed to the back end
   typedef struct packed {
      logic [ACC_BITS-1:0] mantissa;
      logic [ACC_BITS-1:0] divisor;
      logic [1:0]          unit;
      logic                sat;
   } job_type;

   // reserved code reads as degrees
   function automatic logic [1:0] unit_code(input logic [1:0] u);
      logic [1:0] r;
      r = (u == UNIT_GON || u == UNIT_RAD) ? u : UNIT_DEG;
      return r;
   endfunction

   function automatic logic [63:0] unit_scale(input logic [1:0] u);
      logic [63:0] s;
      case (u)
         UNIT_GON: s = SCALE_GON;
         UNIT_RAD: s = SCALE_RAD;
         default:  s = SCALE_DEG;
      endcase
      return s;
   endfunction

endpackage

// ===== src/atb_front.sv =====
`timescale 1ns / 1ps
module atb_front import atb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_word,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
   localparam logic [ACC_BITS-1:0] ACC_ONE = ACC_BITS'(1);

   localparam logic [7:0] CONT_LO     = 8'h80;
   localparam logic [7:0] LEAD2_LO    = 8'hC0;
   localparam logic [7:0] LEAD3_LO    = 8'hE0;
   localparam logic [7:0] LEAD4_LO    = 8'hF0;
   localparam logic [7:0] BYTE_MAX    = 8'hFF;
   localparam logic [7:0] ASCII_LO    = 8'h00;
   localparam logic [7:0] ASCII_SYM   = 8'h3F;
   localparam logic [7:0] CHR_HYPHEN  = 8'h2D;
   localparam logic [7:0] CHR_APOS    = 8'h27;
   localparam logic [7:0] CHR_QUOTE   = 8'h22;
   localparam logic [7:0] CHR_POINT   = 8'h2E;
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_NINE    = 8'h39;
   localparam logic [7:0] CHR_LOWER_G = 8'h67;
   localparam logic [7:0] CHR_UPPER_G = 8'h47;

   localparam logic [23:0] SYM_DEGREE = 24'h00C2B0;
   localparam logic [23:0] SYM_PRIME  = 24'hE280B2;
   localparam logic [23:0] SYM_DPRIME = 24'hE280B3;

   logic [ACC_BITS-1:0] mantissa_ff, mantissa_in;
   logic [ACC_BITS-1:0] divisor_ff, divisor_in;
   logic                point_ff, point_in;
   logic                sixfold_ff, sixfold_in;
   logic [1:0]          unit_ff, unit_in;
   logic [1:0]          dflt_unit_ff, dflt_unit_in;
   logic [23:0]         utf_bytes_ff, utf_bytes_in;
   logic [1:0]          utf_rem_ff, utf_rem_in;
   logic                sat_ff, sat_in;

   logic                accept;
   logic [7:0]          c;
   logic [ACC_BITS:0]   man_mac;
   logic [ACC_BITS:0]   div_mac;

   // v * (6 or 10) + add, clamped to ACC_MAX; top bit flags the clamp
   function automatic logic [ACC_BITS:0] sat_mac(input logic [ACC_BITS-1:0] v,
                                                 input logic six,
                                                 input logic [3:0] add);
      logic [ACC_BITS+3:0] ve;
      logic [ACC_BITS+3:0] sum;
      logic [ACC_BITS:0]   r;
      ve  = (ACC_BITS+4)'(v);
      sum = (six ? (ve << 2) : (ve << 3)) + (ve << 1) + (ACC_BITS+4)'(add);
      if (sum[ACC_BITS+3:ACC_BITS] != 4'd0) begin
         r = {1'b1, ACC_MAX};
      end else begin
         r = {1'b0, sum[ACC_BITS-1:0]};
      end
      return r;
   endfunction

   assign c         = req_word.char_byte;
   assign req_stall = req_word.last_byte & q_full;
   assign accept    = req_valid & ~req_stall;
   assign man_mac   = sat_mac(mantissa_ff, sixfold_ff, c[3:0]);
   assign div_mac   = sat_mac(divisor_ff, sixfold_ff, 4'd0);

   always_comb begin
      mantissa_in  = mantissa_ff;
      divisor_in   = divisor_ff;
      point_in     = point_ff;
      sixfold_in   = sixfold_ff;
      unit_in      = unit_ff;
      dflt_unit_in = dflt_unit_ff;
      utf_bytes_in = utf_bytes_ff;
      utf_rem_in   = utf_rem_ff;
      sat_in       = sat_ff;
      q_push       = 1'b0;

      if (accept) begin
         case (c) inside
            [LEAD2_LO:LEAD4_LO-8'd1]: begin
               utf_bytes_in = 24'(c);
               utf_rem_in   = (c < LEAD3_LO) ? 2'd1 : 2'd2;
            end
            [LEAD4_LO:BYTE_MAX]: begin
               utf_bytes_in = '0;
               utf_rem_in   = 2'd0;
            end
            [CONT_LO:LEAD2_LO-8'd1]: begin
               if (utf_rem_ff != 2'd0) begin
                  utf_bytes_in = {utf_bytes_ff[15:0], c};
                  utf_rem_in   = utf_rem_ff - 2'd1;
                  if (utf_rem_in == 2'd0 &&
                      (utf_bytes_in == SYM_DEGREE || utf_bytes_in == SYM_PRIME ||
                       utf_bytes_in == SYM_DPRIME)) begin
                     point_in   = 1'b1;
                     sixfold_in = 1'b1;
                     unit_in    = UNIT_DEG;
                  end
               end
            end
            CHR_LOWER_G, CHR_UPPER_G: begin
               utf_rem_in = 2'd0;
               unit_in    = UNIT_GON;
            end
            [ASCII_LO:ASCII_SYM]: begin
               utf_rem_in = 2'd0;
               case (c) inside
                  CHR_HYPHEN, CHR_APOS, CHR_QUOTE: begin
                     point_in   = 1'b1;
                     sixfold_in = 1'b1;
                     unit_in    = UNIT_DEG;
                  end
                  CHR_POINT: begin
                     point_in = 1'b1;
                  end
                  [CHR_ZERO:CHR_NINE]: begin
                     mantissa_in = man_mac[ACC_BITS-1:0];
                     sat_in      = sat_ff | man_mac[ACC_BITS];
                     if (point_ff) begin
                        divisor_in = div_mac[ACC_BITS-1:0];
                        sat_in     = sat_ff | man_mac[ACC_BITS] | div_mac[ACC_BITS];
                     end
                     sixfold_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
               utf_rem_in = 2'd0;
            end
         endcase
      end

      q_job.mantissa = mantissa_in;
      q_job.divisor  = divisor_in;
      q_job.unit     = unit_in;
      q_job.sat      = sat_in;

      // end of string: hand off and start over
      if (accept && req_word.last_byte) begin
         q_push       = 1'b1;
         mantissa_in  = '0;
         divisor_in   = ACC_ONE;
         point_in     = 1'b0;
         sixfold_in   = 1'b0;
         utf_bytes_in = '0;
         utf_rem_in   = 2'd0;
         sat_in       = 1'b0;
         unit_in      = unit_code(dflt_unit_ff);
      end

      if (csr_wr_en) begin
         dflt_unit_in = csr_wr_data;
         unit_in      = unit_code(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mantissa_ff  <= '0;
         divisor_ff   <= ACC_ONE;
         point_ff     <= 1'b0;
         sixfold_ff   <= 1'b0;
         unit_ff      <= UNIT_DEG;
         dflt_unit_ff <= UNIT_DEG;
         utf_bytes_ff <= '0;
         utf_rem_ff   <= 2'd0;
         sat_ff       <= 1'b0;
      end else begin
         mantissa_ff  <= mantissa_in;
         divisor_ff   <= divisor_in;
         point_ff     <= point_in;
         sixfold_ff   <= sixfold_in;
         unit_ff      <= unit_in;
         dflt_unit_ff <= dflt_unit_in;
         utf_bytes_ff <= utf_bytes_in;
         utf_rem_ff   <= utf_rem_in;
         sat_ff       <= sat_in;
      end
   end

endmodule

// ===== src/atb_queue.sv =====
`timescale 1ns / 1ps
module atb_queue import atb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type pop_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/atb_back.sv =====
`timescale 1ns / 1ps
module atb_back import atb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  job_type q_job,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int MAN_CHUNKS = (ACC_BITS + 31) / 32;
   localparam int PAD_BITS   = MAN_CHUNKS * 32;
   localparam int NPP        = MAN_CHUNKS * 2;
   localparam int PP_IDX_W   = $clog2(NPP);
   localparam int STEP_W     = $clog2(NPP + 1);
   localparam int PROD_BITS  = ACC_BITS + 64;
   localparam int DCNT_W     = $clog2(PROD_BITS);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_type;

   state_type             state_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DCNT_W-1:0]     dcnt_ff;
   logic [PAD_BITS-1:0]   man_ff;
   logic [63:0]           scale_ff;
   logic [ACC_BITS-1:0]   div_ff;
   logic [1:0]            unit_ff;
   logic                  sat_ff;
   logic [PROD_BITS-1:0]  pp_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [ACC_BITS-1:0]   rem_ff;
   logic [63:0]           quo_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_word_ff;

   logic [PP_IDX_W-1:0]        pp_k;
   logic [PP_IDX_W-1:0]        pp_pos;
   logic [PAD_BITS-1:0]        man_sh;
   logic [63:0]                scl_sh;
   logic [63:0]                pp64;
   logic [PAD_BITS+63:0]       pp_wide;
   logic [ACC_BITS:0]          r2;
   logic [ACC_BITS:0]          rdiff;
   logic                       ge;
   logic [33:0]                rnd;
   logic                       slot_free;

   // partial product k: mantissa chunk k/2 times scale chunk k%2
   always_comb begin
      pp_k    = step_ff[PP_IDX_W-1:0];
      pp_pos  = (pp_k >> 1) + PP_IDX_W'(pp_k[0]);
      man_sh  = man_ff >> {pp_k >> 1, 5'd0};
      scl_sh  = scale_ff >> {pp_k[0], 5'd0};
      pp64    = man_sh[31:0] * scl_sh[31:0];
      pp_wide = (PAD_BITS + 64)'(pp64) << {pp_pos, 5'd0};
   end

   // one restoring divide step per cycle, product fed in msb first
   always_comb begin
      r2    = {rem_ff, prod_ff[PROD_BITS-1]};
      rdiff = r2 - {1'b0, div_ff};
      ge    = (r2 >= {1'b0, div_ff});
   end

   // round half up on 32 fraction bits of the quotient
   assign rnd       = {1'b0, quo_ff[63:31]} + 34'd1;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) & q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  man_ff   <= PAD_BITS'(q_job.mantissa);
                  scale_ff <= unit_scale(q_job.unit);
                  div_ff   <= (q_job.divisor == '0) ? ACC_BITS'(1) : q_job.divisor;
                  unit_ff  <= q_job.unit;
                  sat_ff   <= q_job.sat;
                  pp_ff    <= '0;
                  prod_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // add trails the multiply, taking pp_ff registered in the cycle before
               prod_ff <= prod_ff + pp_ff;
               pp_ff   <= (step_ff < STEP_W'(NPP)) ? pp_wide[PROD_BITS-1:0] : '0;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(NPP)) begin
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  dcnt_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               prod_ff <= prod_ff << 1;
               rem_ff  <= ge ? rdiff[ACC_BITS-1:0] : r2[ACC_BITS-1:0];
               quo_ff  <= {quo_ff[62:0], ge};
               dcnt_ff <= dcnt_ff + DCNT_W'(1);
               if (dcnt_ff == DCNT_W'(PROD_BITS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // a word taken at this edge is replaced, so valid stays set
               if (slot_free) begin
                  rsp_word_ff.bin_angle <= rnd[32:1];
                  rsp_word_ff.overflow  <= sat_ff;
                  rsp_word_ff.unit_used <= unit_ff;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/angle_text_to_binary_angle_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                          Moves one word of
// -------   -----------------------------  --------------------------------------
// req       req_valid req_stall req_word   text byte + end-of-string mark
// rsp       rsp_valid rsp_stall rsp_word   binary angle, overflow, unit
// csr       csr_wr_en csr_wr_data          default unit (write only)
//
// Front parser takes one byte per cycle; only a last byte stalls, and only when
// the two-entry string queue is full.
// Back end per string: load, multiply/accumulate of NPP partial products,
// ACC_BITS+64 restoring divide steps by the one-bit-per-cycle divider, then
// the output register, where rsp_stall holds a word without blocking the next
// pop. Synchronous active-high reset clears parse, queue, valid.
module angle_text_to_binary_angle_core import atb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_word,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   // parser -> queue
   logic    q_push;
   logic    q_full;
   job_type q_push_job;

   // queue -> back end
   logic    q_pop;
   logic    q_valid;
   job_type q_pop_job;

   atb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_push_job)
   );

   atb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_job   (q_pop_job)
   );

   atb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (q_pop_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // a finished string never lands on a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("string pushed into full queue");

   // back end only pops real entries
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // stall on the input side only ever comes from a full queue
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (q_full && req_word.last_byte))
      else $error("input stalled without full queue");

   // reported unit is always a real unit
   a_unit_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.unit_used != UNIT_RSVD))
      else $error("reserved unit code on output");

endmodule
